// ===== src/rational_arith_unit_defines.svh =====
// Assertion macros shared by the rational arithmetic unit files.
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define RAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("rau check failed");
`define RAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("rau check failed");
`else
`define RAU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RAU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/rau_pkg.sv =====
`timescale 1ns / 1ps
package rau_pkg;

	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_EQ  = 3'd4;

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_ERR = 2'd1;
	localparam logic [1:0] STAT_OVF = 2'd2;

	typedef enum logic [1:0] {
		OP_GCD = 2'd0,
		OP_DIV = 2'd1,
		OP_MUL = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

endpackage

// ===== src/rau_alu.sv =====
`timescale 1ns / 1ps
`include "rational_arith_unit_defines.svh"
module rau_alu import rau_pkg::*; #(
	parameter int MAG_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  alu_req_t              req,
	input  logic [2*MAG_BITS:0]   opa,
	input  logic [2*MAG_BITS:0]   opb,
	output logic                  done,
	output logic [2*MAG_BITS:0]   res
);

	localparam int VW = 2 * MAG_BITS + 1;
	localparam int CW = $clog2(VW + 1);
	localparam logic [CW-1:0] CNT_LAST = CW'(VW - 1);

	typedef enum logic [3:0] {
		U_IDLE = 4'b0001,
		U_GCD  = 4'b0010,
		U_SHL  = 4'b0100,
		U_DIV  = 4'b1000
	} ustate_t;

	ustate_t       state_q;
	logic [VW-1:0] x_q, y_q, res_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [VW:0]   trial;
	logic          qbit;
	logic [VW-1:0] q_nxt;

	assign trial = {x_q, y_q[VW-1]};
	assign qbit  = trial >= {1'b0, dvs_q};
	assign q_nxt = {y_q[VW-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				U_IDLE: begin
					if (req.start) begin
						case (req.op)
							OP_GCD: begin
								x_q     <= opa;
								y_q     <= opb;
								cnt_q   <= '0;
								state_q <= U_GCD;
							end
							OP_DIV: begin
								x_q     <= '0;
								y_q     <= opa;
								dvs_q   <= opb;
								cnt_q   <= '0;
								state_q <= U_DIV;
							end
							OP_MUL: begin
								res_q  <= VW'(opa[MAG_BITS-1:0] * opb[MAG_BITS-1:0]);
								done_q <= 1'b1;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				U_GCD: begin
					if (y_q == '0) begin
						res_q   <= x_q;
						state_q <= U_SHL;
					end else if (x_q == '0) begin
						res_q   <= y_q;
						state_q <= U_SHL;
					end else if (!x_q[0] && !y_q[0]) begin
						x_q   <= x_q >> 1;
						y_q   <= y_q >> 1;
						cnt_q <= cnt_q + 1'b1;
					end else if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else if (!y_q[0]) begin
						y_q <= y_q >> 1;
					end else if (x_q >= y_q) begin
						x_q <= (x_q - y_q) >> 1;
					end else begin
						y_q <= (y_q - x_q) >> 1;
					end
				end
				U_SHL: begin
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end else begin
						res_q <= res_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				U_DIV: begin
					if (qbit)
						x_q <= VW'(trial - {1'b0, dvs_q});
					else
						x_q <= trial[VW-1:0];
					y_q   <= q_nxt;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						res_q   <= q_nxt;
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;

	`RAU_ASSERT_IMP(a_start_idle, clk, arst_n, req.start, state_q == U_IDLE)
	`RAU_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == U_IDLE)
	`RAU_ASSERT_NXT(a_div_busy, clk, arst_n, req.start && req.op == OP_DIV, state_q == U_DIV)

endmodule

// ===== src/rational_arith_unit.sv =====
`timescale 1ns / 1ps
// Rational arithmetic unit: adds, subtracts, multiplies, divides or compares two signed
// fractions and returns the result in lowest terms (zero as +0/1). One beat is worked at a
// time by a single shared GCD / divide / multiply unit under a step sequencer; a beat's run time
// is set by the bit-serial divider (four to six divides per beat) and the binary GCD (two or
// three GCDs). Zero denominators, a zero divisor and undefined actions return status 1,
// going straight to the output step; a sum that still needs more than 64 bits in lowest terms
// saturates with status 2. A finished result sits in the output register while the next
// beat is taken.
`include "rational_arith_unit_defines.svh"
module rational_arith_unit import rau_pkg::*; #(
	parameter int MAG_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic        left_negative,
	input  logic [31:0] left_numer,
	input  logic [31:0] left_denom,
	input  logic        right_negative,
	input  logic [31:0] right_numer,
	input  logic [31:0] right_denom,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_negative,
	output logic [63:0] out_numer,
	output logic [63:0] out_denom,
	output logic        is_equal,
	output logic [1:0]  status
);

	localparam int  MB      = MAG_BITS;
	localparam int  VW      = 2 * MB + 1;
	localparam bit  CAN_OVF = (2 * MB >= 64);

	typedef enum logic [18:0] {
		S_IDLE  = 19'b1 << 0,
		S_GCD_A = 19'b1 << 1,
		S_GCD_B = 19'b1 << 2,
		S_DIV_A = 19'b1 << 3,
		S_DIV_C = 19'b1 << 4,
		S_MUL_N = 19'b1 << 5,
		S_EQ_N  = 19'b1 << 6,
		S_DIV_E = 19'b1 << 7,
		S_DIV_B = 19'b1 << 8,
		S_MUL_D = 19'b1 << 9,
		S_EQ_D  = 19'b1 << 10,
		S_ADD_L = 19'b1 << 11,
		S_ADD_1 = 19'b1 << 12,
		S_ADD_2 = 19'b1 << 13,
		S_SUM   = 19'b1 << 14,
		S_RED_G = 19'b1 << 15,
		S_RED_N = 19'b1 << 16,
		S_RED_D = 19'b1 << 17,
		S_OUT   = 19'b1 << 18
	} state_t;

	state_t          state_q;
	logic            pend_q;
	logic [2:0]      act_q;
	logic            lneg_q, rneg_q, err_q, neg_q, eqn_q, eq_q, ovf_q;
	logic [MB-1:0]   ln_q, rn_q, rd_q;
	logic [MB-1:0]   a_q, b_q, c_q, e_q, g1_q, g2_q, t1_q, t2_q;
	logic [2*MB-1:0] s1_q, s2_q, den_q, dres_q;
	logic [VW-1:0]   num_q, g_q, nres_q;

	logic            out_valid_q, out_neg_q, out_eq_q;
	logic [63:0]     out_n_q, out_d_q;
	logic [1:0]      out_st_q;

	logic [MB-1:0]   m_ln, m_ld, m_rn, m_rd;
	logic            in_acc, in_err, is_add;
	alu_req_t        req;
	logic            use_op, alu_done;
	logic [VW-1:0]   opa, opb, alu_res;
	logic            sneg;

	assign m_ln   = left_numer[MB-1:0];
	assign m_ld   = left_denom[MB-1:0];
	assign m_rn   = right_numer[MB-1:0];
	assign m_rd   = right_denom[MB-1:0];
	assign in_acc = in_valid && !in_stall;
	assign in_err = (m_ld == '0) || (m_rd == '0) || (action > ACT_EQ) ||
		((action == ACT_DIV) && (m_rn == '0));
	assign is_add = (act_q == ACT_ADD) || (act_q == ACT_SUB);
	assign sneg   = (act_q == ACT_SUB) ? !rneg_q : rneg_q;

	always_comb begin
		use_op = 1'b1;
		req.op = OP_GCD;
		opa    = '0;
		opb    = '0;
		case (state_q)
			S_GCD_A: begin opa = VW'(a_q); opb = VW'(e_q); end
			S_GCD_B: begin opa = VW'(c_q); opb = VW'(b_q); end
			S_DIV_A: begin req.op = OP_DIV; opa = VW'(a_q); opb = VW'(g1_q); end
			S_DIV_C: begin req.op = OP_DIV; opa = VW'(c_q); opb = VW'(g2_q); end
			S_DIV_E: begin req.op = OP_DIV; opa = VW'(e_q); opb = VW'(g1_q); end
			S_DIV_B: begin req.op = OP_DIV; opa = VW'(b_q); opb = VW'(g2_q); end
			S_MUL_N, S_MUL_D: begin req.op = OP_MUL; opa = VW'(t1_q); opb = VW'(t2_q); end
			S_ADD_L: begin req.op = OP_MUL; opa = VW'(t1_q); opb = VW'(rd_q); end
			S_ADD_1: begin req.op = OP_MUL; opa = VW'(t2_q); opb = VW'(ln_q); end
			S_ADD_2: begin req.op = OP_MUL; opa = VW'(t1_q); opb = VW'(rn_q); end
			S_RED_G: begin opa = num_q; opb = VW'(den_q); end
			S_RED_N: begin req.op = OP_DIV; opa = num_q; opb = g_q; end
			S_RED_D: begin req.op = OP_DIV; opa = VW'(den_q); opb = g_q; end
			default: use_op = 1'b0;
		endcase
		req.start = use_op && !pend_q;
	end

	rau_alu #(.MAG_BITS(MAG_BITS)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.done   (alu_done),
		.res    (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_OUT))
				out_valid_q <= 1'b0;
			if (alu_done)
				pend_q <= 1'b0;
			else if (req.start)
				pend_q <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						act_q  <= action;
						lneg_q <= left_negative;
						rneg_q <= right_negative;
						ln_q   <= m_ln;
						rn_q   <= m_rn;
						rd_q   <= m_rd;
						err_q  <= in_err;
						ovf_q  <= 1'b0;
						eq_q   <= 1'b0;
						if ((action == ACT_ADD) || (action == ACT_SUB)) begin
							a_q <= m_ld; e_q <= m_rd; c_q <= m_rd; b_q <= m_ld;
						end else if (action == ACT_MUL) begin
							a_q <= m_ln; b_q <= m_ld; c_q <= m_rn; e_q <= m_rd;
						end else if (action == ACT_DIV) begin
							a_q <= m_ln; b_q <= m_ld; c_q <= m_rd; e_q <= m_rn;
						end else begin
							a_q <= m_ln; e_q <= m_ld; c_q <= m_rn; b_q <= m_rd;
						end
						state_q <= in_err ? S_OUT : S_GCD_A;
					end
				end
				S_GCD_A: if (alu_done) begin
					g1_q <= alu_res[MB-1:0];
					g2_q <= alu_res[MB-1:0];
					state_q <= is_add ? S_DIV_A : S_GCD_B;
				end
				S_GCD_B: if (alu_done) begin
					g2_q <= alu_res[MB-1:0];
					state_q <= S_DIV_A;
				end
				S_DIV_A: if (alu_done) begin
					t1_q <= alu_res[MB-1:0];
					state_q <= S_DIV_C;
				end
				S_DIV_C: if (alu_done) begin
					t2_q <= alu_res[MB-1:0];
					if (is_add)
						state_q <= S_ADD_L;
					else if (act_q == ACT_EQ)
						state_q <= S_EQ_N;
					else
						state_q <= S_MUL_N;
				end
				S_MUL_N: if (alu_done) begin
					num_q <= alu_res;
					state_q <= S_DIV_E;
				end
				S_EQ_N: begin
					eqn_q <= (t1_q == t2_q);
					state_q <= S_DIV_E;
				end
				S_DIV_E: if (alu_done) begin
					t1_q <= alu_res[MB-1:0];
					state_q <= S_DIV_B;
				end
				S_DIV_B: if (alu_done) begin
					t2_q <= alu_res[MB-1:0];
					state_q <= (act_q == ACT_EQ) ? S_EQ_D : S_MUL_D;
				end
				S_MUL_D: if (alu_done) begin
					den_q <= alu_res[2*MB-1:0];
					neg_q <= lneg_q ^ rneg_q;
					state_q <= S_RED_G;
				end
				S_EQ_D: begin
					eq_q <= eqn_q && (t1_q == t2_q) &&
						((lneg_q && ln_q != '0) == (rneg_q && rn_q != '0));
					state_q <= S_OUT;
				end
				S_ADD_L: if (alu_done) begin
					den_q <= alu_res[2*MB-1:0];
					state_q <= S_ADD_1;
				end
				S_ADD_1: if (alu_done) begin
					s1_q <= alu_res[2*MB-1:0];
					state_q <= S_ADD_2;
				end
				S_ADD_2: if (alu_done) begin
					s2_q <= alu_res[2*MB-1:0];
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (lneg_q == sneg) begin
						num_q <= {1'b0, s1_q} + {1'b0, s2_q};
						neg_q <= lneg_q;
					end else if (s1_q > s2_q) begin
						num_q <= {1'b0, s1_q - s2_q};
						neg_q <= lneg_q;
					end else begin
						num_q <= {1'b0, s2_q - s1_q};
						neg_q <= sneg;
					end
					state_q <= S_RED_G;
				end
				S_RED_G: if (alu_done) begin
					g_q   <= alu_res;
					ovf_q <= CAN_OVF && num_q[VW-1] && (alu_res == VW'(1));
					state_q <= S_RED_N;
				end
				S_RED_N: if (alu_done) begin
					nres_q <= alu_res;
					state_q <= S_RED_D;
				end
				S_RED_D: if (alu_done) begin
					dres_q <= alu_res[2*MB-1:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_eq_q    <= 1'b0;
						out_neg_q   <= 1'b0;
						out_n_q     <= '0;
						out_d_q     <= '0;
						out_st_q    <= STAT_OK;
						if (err_q) begin
							out_st_q <= STAT_ERR;
						end else if (act_q == ACT_EQ) begin
							out_eq_q <= eq_q;
						end else if (ovf_q) begin
							out_st_q  <= STAT_OVF;
							out_neg_q <= neg_q;
							out_n_q   <= '1;
							out_d_q   <= 64'(den_q);
						end else if (nres_q == '0) begin
							out_d_q <= 64'd1;
						end else begin
							out_neg_q <= neg_q;
							out_n_q   <= 64'(nres_q);
							out_d_q   <= 64'(dres_q);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign out_negative = out_neg_q;
	assign out_numer    = out_n_q;
	assign out_denom    = out_d_q;
	assign is_equal     = out_eq_q;
	assign status       = out_st_q;

	`RAU_ASSERT_NXT(a_acc_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	`RAU_ASSERT_IMP(a_err_zero, clk, arst_n, out_valid_q && out_st_q == STAT_ERR, out_n_q == '0 && out_d_q == '0 && !out_eq_q)
	`RAU_ASSERT_IMP(a_ovf_sat, clk, arst_n, out_valid_q && out_st_q == STAT_OVF, out_n_q == '1)

endmodule

// ===== bench/tb_rational_arith_unit.sv =====
`timescale 1ns / 1ps
module tb_rational_arith_unit;
	import rau_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic        neg;
		logic [63:0] numer;
		logic [63:0] denom;
		logic        eq;
		logic [1:0]  stat;
	} frac_result_t;

	class frac_scoreboard;
		frac_result_t pending[$];
		int mismatches;
		int checked;

		function logic [63:0] gcd(logic [63:0] a, logic [63:0] b);
			logic [63:0] t;
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			return a;
		endfunction

		function bit reduce_wide(logic [63:0] carry, logic [63:0] lo, logic [63:0] den,
				output logic [63:0] n, output logic [63:0] d);
			logic [63:0] g, r, p, m, qa, ra, qb, rb, all1;
			all1 = '1;
			if (carry == 0) begin
				g = gcd(lo, den);
				if (g == 0) g = 1;
				n = lo / g;
				d = den / g;
				return 0;
			end
			r = lo % den;
			p = ((all1 % den) + 1) % den;
			m = (r >= den - p) ? r - (den - p) : r + p;
			g = gcd(den, m);
			if (g <= 1) begin
				n = all1;
				d = den;
				return 1;
			end
			qa = all1 / g;
			ra = (all1 % g) + 1;
			if (ra == g) begin
				qa++;
				ra = 0;
			end
			qb = lo / g;
			rb = lo % g;
			n = qa + qb + ((ra + rb >= g) ? 1 : 0);
			d = den / g;
			return 0;
		endfunction

		function void cross_product(logic [63:0] a, logic [63:0] b, logic [63:0] c,
				logic [63:0] e, output logic [63:0] n, output logic [63:0] d);
			logic [63:0] g1, g2, pn, pd, g;
			g1 = gcd(a, e);
			g2 = gcd(c, b);
			if (g1 == 0) g1 = 1;
			if (g2 == 0) g2 = 1;
			pn = (a / g1) * (c / g2);
			pd = (e / g1) * (b / g2);
			g = gcd(pn, pd);
			if (g == 0) g = 1;
			n = pn / g;
			d = pd / g;
		endfunction

		function void note_operands(logic [2:0] act, logic lneg, logic [31:0] lnum,
				logic [31:0] lden, logic rneg, logic [31:0] rnum, logic [31:0] rden);
			frac_result_t r;
			logic [63:0] ln, ld, rn, rd, g, g1, g2, lcm, t1, t2, s, n, d;
			logic sneg;
			ln = lnum; ld = lden; rn = rnum; rd = rden;
			n = 0; d = 0;
			r.neg = 0; r.eq = 0; r.stat = STAT_OK;
			if (ld == 0 || rd == 0 || act > ACT_EQ || (act == ACT_DIV && rn == 0)) begin
				r.stat = STAT_ERR;
			end else if (act == ACT_EQ) begin
				g1 = gcd(ln, ld);
				g2 = gcd(rn, rd);
				r.eq = ((lneg && ln != 0) == (rneg && rn != 0) && ln / g1 == rn / g2
					&& ld / g1 == rd / g2);
			end else if (act == ACT_MUL) begin
				cross_product(ln, ld, rn, rd, n, d);
				r.neg = lneg != rneg;
			end else if (act == ACT_DIV) begin
				cross_product(ln, ld, rd, rn, n, d);
				r.neg = lneg != rneg;
			end else begin
				g = gcd(ld, rd);
				lcm = (ld / g) * rd;
				t1 = (lcm / ld) * ln;
				t2 = (lcm / rd) * rn;
				sneg = (act == ACT_SUB) ? !rneg : rneg;
				if (lneg == sneg) begin
					s = t1 + t2;
					if (reduce_wide((s < t1) ? 64'd1 : 64'd0, s, lcm, n, d))
						r.stat = STAT_OVF;
					r.neg = lneg;
				end else if (t1 > t2) begin
					void'(reduce_wide(0, t1 - t2, lcm, n, d));
					r.neg = lneg;
				end else if (t1 < t2) begin
					void'(reduce_wide(0, t2 - t1, lcm, n, d));
					r.neg = sneg;
				end else begin
					n = 0;
					d = 1;
				end
			end
			if (r.stat == STAT_ERR || act == ACT_EQ) begin
				n = 0;
				d = 0;
				r.neg = 0;
			end
			if (n == 0 && d != 0) begin
				d = 1;
				r.neg = 0;
			end
			r.numer = n;
			r.denom = d;
			pending.push_back(r);
		endfunction

		function void check_result(frac_result_t got);
			frac_result_t want;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat");
				return;
			end
			want = pending.pop_front();
			if (want != got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp neg=%0d %0d/%0d eq=%0d st=%0d, got neg=%0d %0d/%0d eq=%0d st=%0d",
						want.neg, want.numer, want.denom, want.eq, want.stat,
						got.neg, got.numer, got.denom, got.eq, got.stat);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] action = ACT_ADD;
	logic left_negative = 0;
	logic [31:0] left_numer = 0;
	logic [31:0] left_denom = 0;
	logic right_negative = 0;
	logic [31:0] right_numer = 0;
	logic [31:0] right_denom = 0;
	logic out_valid;
	logic out_stall = 0;
	logic out_negative;
	logic [63:0] out_numer;
	logic [63:0] out_denom;
	logic is_equal;
	logic [1:0] status;

	frac_scoreboard fsb = new();
	bit quiet_out = 0;
	bit hold_out = 0;
	bit quiet_in = 0;
	int idle_cycles = 0;
	int sent = 0;

	rational_arith_unit uut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			fsb.check_result('{out_negative, out_numer, out_denom, is_equal, status});
		if (arst_n && (in_valid && !in_stall || out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		out_stall <= hold_out || (!quiet_out && $urandom_range(99) < 6);
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("Test completed with failures");
			$finish;
		end
	end

	function logic [31:0] rand_mag();
		case ($urandom_range(5))
			0: return $urandom_range(3);
			1: return 32'hFFFF_FFFF - $urandom_range(3);
			2: return $urandom_range(40);
			3: return $urandom_range(5000);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_beat(logic [2:0] act, logic ln_s, logic [31:0] ln, logic [31:0] ld,
			logic rn_s, logic [31:0] rn, logic [31:0] rd);
		while (!quiet_in && $urandom_range(99) < 6) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		left_negative <= ln_s;
		left_numer <= ln;
		left_denom <= ld;
		right_negative <= rn_s;
		right_numer <= rn;
		right_denom <= rd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		fsb.note_operands(act, ln_s, ln, ld, rn_s, rn, rd);
		sent++;
	endtask

	task automatic send_random();
		logic [2:0] act;
		logic [31:0] ld, rd;
		act = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
		ld = rand_mag();
		rd = rand_mag();
		if ($urandom_range(9) != 0 && ld == 0) ld = 1;
		if ($urandom_range(9) != 0 && rd == 0) rd = 7;
		send_beat(act, 1'($urandom_range(1)), rand_mag(), ld, 1'($urandom_range(1)),
			rand_mag(), rd);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (fsb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		int a;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (a = 0; a <= 7; a++)
			send_beat(3'(a), 1, 32'd6, 32'd4, 0, 32'd3, 32'd9);
		send_beat(ACT_ADD, 0, '1, '1, 0, '1, 32'hFFFF_FFFE);
		send_beat(ACT_ADD, 0, '1, 32'hFFFF_FFFE, 0, '1, 32'hFFFF_FFFD);
		send_beat(ACT_SUB, 1, '1, 32'd1, 0, '1, 32'd3);
		send_beat(ACT_ADD, 0, 32'd0, 32'd5, 1, 32'd0, 32'd9);
		send_beat(ACT_SUB, 1, 32'd3, 32'd4, 1, 32'd6, 32'd8);
		send_beat(ACT_ADD, 1, 32'd1, 32'd3, 0, 32'd2, 32'd3);
		send_beat(ACT_DIV, 0, 32'd5, 32'd7, 1, 32'd0, 32'd3);
		send_beat(ACT_MUL, 0, 32'd5, 32'd0, 0, 32'd1, 32'd2);
		send_beat(ACT_MUL, 1, '1, 32'd1, 1, '1, 32'd1);
		send_beat(ACT_DIV, 0, 32'd1, '1, 0, '1, 32'd1);
		send_beat(ACT_EQ, 1, 32'd0, 32'd3, 0, 32'd0, 32'd7);
		send_beat(ACT_EQ, 1, 32'd2, 32'd4, 1, 32'd1, 32'd2);
		send_beat(ACT_EQ, 1, 32'd2, 32'd4, 0, 32'd1, 32'd2);
		send_beat(ACT_MUL, 0, 32'd0, 32'd9, 1, 32'd4, 32'd3);
		// sender pause until all results are back
		drain();
		// receiver holds off so the block backs up
		hold_out <= 1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_out <= 0;
			end
			repeat (6) send_random();
		join
		quiet_in = 1;
		quiet_out = 1;
		repeat (80) send_random();
		quiet_in = 0;
		quiet_out = 0;
		while (sent < 425) send_random();
		drain();
		repeat (2000) @(posedge clk);
		$display("%0d operand beats sent, %0d results checked: all actions, errors, overflow",
			sent, fsb.checked);
		if (fsb.mismatches == 0 && fsb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
